FILE: rtl/separable_convolution_replicate_border_assert.svh
`ifndef SEPARABLE_CONVOLUTION_REPLICATE_BORDER_ASSERT_SVH
`define SEPARABLE_CONVOLUTION_REPLICATE_BORDER_ASSERT_SVH

// Same-cycle implication under reset.
`define SCRB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under reset.
`define SCRB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/scrb_pkg.sv
package scrb_pkg;

  localparam int ACC_W = 28;
  localparam int DIV_W = 12;
  localparam int RES_W = 16;
  localparam int NCH   = 3;

  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] REG_THREE_CHAN   = 3'd2;
  localparam logic [2:0] REG_H_TAPS       = 3'd3;
  localparam logic [2:0] REG_V_TAPS       = 3'd4;
  localparam logic [2:0] REG_NORM_DIV     = 3'd5;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HMAC,
    S_HSTART,
    S_HWAIT,
    S_ADV,
    S_CHK,
    S_VMAC,
    S_VSTART,
    S_VWAIT,
    S_OUT
  } state_e;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic [RES_W-1:0] res_t;

endpackage

FILE: rtl/scrb_div.sv
module scrb_div
  import scrb_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [DIV_W-1:0] divisor_i,
  input  acc_t                    dividend_i [NCH],
  output logic                    done_o,
  output res_t                    quot_o [NCH]
);

  localparam int CNT_W = $clog2(ACC_W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0] dmag_q;
  logic [ACC_W-1:0] q_q   [NCH];
  logic [DIV_W-1:0] rem_q [NCH];
  logic             neg_q [NCH];
  logic [DIV_W:0]   trial [NCH];
  logic             ge    [NCH];

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      trial[ch] = {rem_q[ch], q_q[ch][ACC_W-1]};
      ge[ch]    = trial[ch] >= {1'b0, dmag_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= '0;
        if (divisor_i == '0) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(ACC_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dmag_q <= divisor_i[DIV_W-1] ? DIV_W'(-divisor_i) : divisor_i;
      for (int ch = 0; ch < NCH; ch++) begin
        rem_q[ch] <= '0;
        if (divisor_i == '0) begin
          q_q[ch]   <= dividend_i[ch];
          neg_q[ch] <= 1'b0;
        end else begin
          q_q[ch]   <= dividend_i[ch][ACC_W-1] ? ACC_W'(-dividend_i[ch]) : dividend_i[ch];
          neg_q[ch] <= dividend_i[ch][ACC_W-1] ^ divisor_i[DIV_W-1];
        end
      end
    end else if (busy_q) begin
      for (int ch = 0; ch < NCH; ch++) begin
        rem_q[ch] <= ge[ch] ? DIV_W'(trial[ch] - {1'b0, dmag_q}) : trial[ch][DIV_W-1:0];
        q_q[ch]   <= {q_q[ch][ACC_W-2:0], ge[ch]};
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      quot_o[ch] = neg_q[ch] ? RES_W'(-q_q[ch][RES_W-1:0]) : q_q[ch][RES_W-1:0];
    end
  end

  assign done_o = done_q;

endmodule

FILE: rtl/separable_convolution_replicate_border.sv
// Separable 2D convolution, replicated borders, one or three 8-bit channels in raster order.
// Each item is handled alone: the input side is ready only while the block is idle. A pixel
// costs one horizontal pass per finished column (multiply-accumulate over SPAN taps, then
// normalisation in the shared bit-serial divider, which skips the division with a zero
// divisor), and up to TAPS/2+1 passes on the last column of a row. Each released result
// then costs reads of SPAN entries from the row store (one read port, one entry a cycle), a
// divider pass, and a wait in the output register until taken. Drain beats release one
// pending result each. The row store needs no clearing after reset.
`include "separable_convolution_replicate_border_assert.svh"

module separable_convolution_replicate_border
  import scrb_pkg::*;
#(
  parameter int TAPS      = 3,
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [7:0]  chan_a_i,
  input  logic [7:0]  chan_b_i,
  input  logic [7:0]  chan_c_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [15:0] res_a_o,
  output logic signed [15:0] res_b_o,
  output logic signed [15:0] res_c_o,
  output logic        frame_done_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [55:0] cfg_data_i
);

  localparam int HALF  = TAPS / 2;
  localparam int SPAN  = 2 * HALF + 1;
  localparam int SW    = $clog2(SPAN);
  localparam int CW    = $clog2(MAX_WIDTH + 1);
  localparam int DEPTH = SPAN * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int KW    = $clog2(SPAN + 1);
  localparam int BW    = $clog2(HALF + 2);

  state_e state_q, state_d;

  logic [10:0] fw_q;
  logic [11:0] fh_q;
  logic        tc_q;
  logic [55:0] ht_q, vt_q;
  logic signed [DIV_W-1:0] nd_q;

  logic [CW-1:0] icol_q, ocol_q, hj_q;
  logic [11:0]   irow_q, orow_q;
  logic [SW-1:0] cslot_q, rslot_q, oslot_q, hslot_q, mslot_q, vslot_q;
  logic signed [CW+1:0] hraw_q, mraw_q;
  logic signed [13:0]   vraw_q;
  logic [KW-1:0] k_q;
  logic [BW-1:0] budget_q;
  logic          lastcol_q, last_q;

  logic [7:0] win_q [SPAN][NCH];
  acc_t       acc_q [NCH];
  logic [47:0] mem_q [DEPTH];
  logic [47:0] rdata_q;

  res_t res_q [NCH];
  logic fdone_q;

  logic          div_start, div_done;
  res_t          div_quot [NCH];
  logic          mem_we;
  logic [AW-1:0] waddr, raddr;

  logic [CW-1:0] w_eff;
  logic [11:0]   h_eff;
  logic [12:0]   hm1, nr, orow_p;
  logic [CW:0]   wm1, nc, ocol_p;
  logic          avail, pix_acc, drain_acc, pix_take, out_acc, cfg_wr, restart;
  logic          c_ge_half, c_last, at_last_out;
  logic signed [CW+1:0] mraw_n, hraw_n, wm1_s;
  logic signed [13:0]   vraw_n, hm1_s;
  logic [SW:0]   vs_sum;

  function automatic logic [SW-1:0] inc_slot(input logic [SW-1:0] s);
    inc_slot = (s == SW'(SPAN - 1)) ? '0 : s + SW'(1);
  endfunction

  assign w_eff = (fw_q == '0) ? CW'(1) :
                 ({2'b0, fw_q} > 13'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(fw_q);
  assign h_eff = (fh_q == '0) ? 12'd1 : fh_q;

  assign hm1    = {1'b0, h_eff} - 13'd1;
  assign orow_p = {1'b0, orow_q} + 13'(HALF);
  assign nr     = (orow_p > hm1) ? hm1 : orow_p;
  assign wm1    = {1'b0, w_eff} - (CW+1)'(1);
  assign ocol_p = {1'b0, ocol_q} + (CW+1)'(HALF);
  assign nc     = (ocol_p > wm1) ? wm1 : ocol_p;
  assign avail  = ({1'b0, orow_q} <= hm1) &&
                  (({1'b0, irow_q} > nr) || (({1'b0, irow_q} == nr) && ({1'b0, icol_q} > nc)));

  assign wm1_s  = $signed({2'b0, w_eff}) - (CW+2)'(1);
  assign hm1_s  = $signed({2'b0, h_eff}) - 14'sd1;
  assign mraw_n = mraw_q + (CW+2)'(1);
  assign hraw_n = hraw_q + (CW+2)'(1);
  assign vraw_n = vraw_q + 14'sd1;
  assign vs_sum = {1'b0, oslot_q} + (SW+1)'(HALF + 1);

  assign pix_acc   = in_valid_i && in_ready_o && (opcode_i == OP_PIXEL);
  assign drain_acc = in_valid_i && in_ready_o && (opcode_i == OP_DRAIN);
  assign pix_take  = pix_acc && (irow_q < h_eff);
  assign out_acc   = out_valid_o && out_ready_i;
  assign cfg_wr    = cfg_valid_i && cfg_ready_o;
  assign restart   = cfg_wr && ((cfg_index_i == REG_FRAME_WIDTH) ||
                                (cfg_index_i == REG_FRAME_HEIGHT) ||
                                (cfg_index_i == REG_THREE_CHAN));
  assign c_ge_half   = icol_q >= CW'(HALF);
  assign c_last      = {1'b0, icol_q} == wm1;
  assign at_last_out = ({1'b0, orow_q} == hm1) && ({1'b0, ocol_q} == wm1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (pix_take) begin
          state_d = (c_ge_half || c_last) ? S_HMAC : S_ADV;
        end else if (drain_acc) begin
          state_d = S_CHK;
        end
      end
      S_HMAC:   if (k_q == KW'(SPAN - 1)) state_d = S_HSTART;
      S_HSTART: state_d = S_HWAIT;
      S_HWAIT: begin
        if (div_done) begin
          state_d = (lastcol_q && ({1'b0, hj_q} < wm1)) ? S_HMAC : S_ADV;
        end
      end
      S_ADV:    state_d = S_CHK;
      S_CHK:    state_d = ((budget_q != '0) && avail) ? S_VMAC : S_IDLE;
      S_VMAC:   if (k_q == KW'(SPAN)) state_d = S_VSTART;
      S_VSTART: state_d = S_VWAIT;
      S_VWAIT:  if (div_done) state_d = S_OUT;
      S_OUT:    if (out_ready_i) state_d = S_CHK;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == S_IDLE);
    out_valid_o = (state_q == S_OUT);
    div_start   = (state_q == S_HSTART) || (state_q == S_VSTART);
    mem_we      = (state_q == S_HWAIT) && div_done;
    cfg_ready_o = 1'b1;
  end

  assign waddr = AW'(rslot_q) * AW'(MAX_WIDTH) + AW'(hj_q);
  assign raddr = AW'(vslot_q) * AW'(MAX_WIDTH) + AW'(ocol_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= {div_quot[2], div_quot[1], div_quot[0]};
    end
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (pix_take) begin
      win_q[cslot_q][0] <= chan_a_i;
      win_q[cslot_q][1] <= tc_q ? chan_b_i : 8'd0;
      win_q[cslot_q][2] <= tc_q ? chan_c_i : 8'd0;
    end
  end

  scrb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .divisor_i  (nd_q),
    .dividend_i (acc_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // datapath accumulators and output payload
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE, S_CHK: begin
        for (int ch = 0; ch < NCH; ch++) acc_q[ch] <= '0;
      end
      S_HMAC: begin
        for (int ch = 0; ch < NCH; ch++) begin
          acc_q[ch] <= acc_q[ch] + ACC_W'($signed({1'b0, win_q[mslot_q][ch]}) *
                                          $signed(ht_q[8*k_q +: 8]));
        end
      end
      S_HWAIT: begin
        if (div_done) begin
          for (int ch = 0; ch < NCH; ch++) acc_q[ch] <= '0;
        end
      end
      S_VMAC: begin
        if (k_q != '0) begin
          for (int ch = 0; ch < NCH; ch++) begin
            acc_q[ch] <= acc_q[ch] + ACC_W'($signed(rdata_q[16*ch +: 16]) *
                                            $signed(vt_q[8*(k_q - KW'(1)) +: 8]));
          end
        end
      end
      S_VWAIT: begin
        if (div_done) begin
          res_q[0] <= div_quot[0];
          res_q[1] <= tc_q ? div_quot[1] : '0;
          res_q[2] <= tc_q ? div_quot[2] : '0;
          fdone_q  <= last_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      fw_q      <= 11'd640;
      fh_q      <= 12'd480;
      tc_q      <= 1'b0;
      ht_q      <= '0;
      vt_q      <= '0;
      nd_q      <= '0;
      icol_q    <= '0;
      irow_q    <= '0;
      ocol_q    <= '0;
      orow_q    <= '0;
      cslot_q   <= '0;
      rslot_q   <= '0;
      oslot_q   <= '0;
      hj_q      <= '0;
      hraw_q    <= '0;
      hslot_q   <= '0;
      mraw_q    <= '0;
      mslot_q   <= '0;
      vraw_q    <= '0;
      vslot_q   <= '0;
      k_q       <= '0;
      budget_q  <= '0;
      lastcol_q <= 1'b0;
      last_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          k_q <= '0;
          if (pix_take) begin
            lastcol_q <= c_last;
            if (c_ge_half) begin
              hj_q    <= icol_q - CW'(HALF);
              hraw_q  <= $signed({2'b0, icol_q}) - (CW+2)'(2 * HALF);
              mraw_q  <= $signed({2'b0, icol_q}) - (CW+2)'(2 * HALF);
              hslot_q <= (icol_q >= CW'(2 * HALF)) ? inc_slot(cslot_q) : '0;
              mslot_q <= (icol_q >= CW'(2 * HALF)) ? inc_slot(cslot_q) : '0;
            end else begin
              hj_q    <= '0;
              hraw_q  <= -(CW+2)'(HALF);
              mraw_q  <= -(CW+2)'(HALF);
              hslot_q <= '0;
              mslot_q <= '0;
            end
          end else if (drain_acc) begin
            budget_q <= BW'(1);
          end
        end
        S_HMAC: begin
          k_q    <= k_q + KW'(1);
          mraw_q <= mraw_n;
          if ((mraw_n > 0) && (mraw_n <= wm1_s)) mslot_q <= inc_slot(mslot_q);
        end
        S_HWAIT: begin
          k_q <= '0;
          if (div_done && lastcol_q && ({1'b0, hj_q} < wm1)) begin
            hj_q    <= hj_q + CW'(1);
            hraw_q  <= hraw_n;
            mraw_q  <= hraw_n;
            hslot_q <= (hraw_n > 0) ? inc_slot(hslot_q) : hslot_q;
            mslot_q <= (hraw_n > 0) ? inc_slot(hslot_q) : hslot_q;
          end
        end
        S_ADV: begin
          budget_q <= BW'(HALF + 1);
          if (c_last) begin
            icol_q  <= '0;
            cslot_q <= '0;
            irow_q  <= irow_q + 12'd1;
            rslot_q <= inc_slot(rslot_q);
          end else begin
            icol_q  <= icol_q + CW'(1);
            cslot_q <= inc_slot(cslot_q);
          end
        end
        S_CHK: begin
          k_q    <= '0;
          last_q <= at_last_out;
          vraw_q <= $signed({2'b0, orow_q}) - 14'(HALF);
          if (orow_q >= 12'(HALF)) begin
            vslot_q <= (vs_sum >= (SW+1)'(SPAN)) ? SW'(vs_sum - (SW+1)'(SPAN)) : SW'(vs_sum);
          end else begin
            vslot_q <= '0;
          end
        end
        S_VMAC: begin
          if (k_q != KW'(SPAN)) begin
            k_q    <= k_q + KW'(1);
            vraw_q <= vraw_n;
            if ((vraw_n > 0) && (vraw_n <= hm1_s)) vslot_q <= inc_slot(vslot_q);
          end
        end
        S_OUT: begin
          if (out_ready_i) begin
            budget_q <= budget_q - BW'(1);
            if (last_q) begin
              icol_q  <= '0;
              irow_q  <= '0;
              ocol_q  <= '0;
              orow_q  <= '0;
              cslot_q <= '0;
              rslot_q <= '0;
              oslot_q <= '0;
            end else if ({1'b0, ocol_q} == wm1) begin
              ocol_q  <= '0;
              orow_q  <= orow_q + 12'd1;
              oslot_q <= inc_slot(oslot_q);
            end else begin
              ocol_q <= ocol_q + CW'(1);
            end
          end
        end
        default: ;
      endcase

      if (cfg_wr) begin
        case (cfg_index_i)
          REG_FRAME_WIDTH:  fw_q <= cfg_data_i[10:0];
          REG_FRAME_HEIGHT: fh_q <= cfg_data_i[11:0];
          REG_THREE_CHAN:   tc_q <= cfg_data_i[0];
          REG_H_TAPS:       ht_q <= cfg_data_i;
          REG_V_TAPS:       vt_q <= cfg_data_i;
          REG_NORM_DIV:     nd_q <= cfg_data_i[11:0];
          default: ;
        endcase
      end
      if (restart) begin
        icol_q  <= '0;
        irow_q  <= '0;
        ocol_q  <= '0;
        orow_q  <= '0;
        cslot_q <= '0;
        rslot_q <= '0;
        oslot_q <= '0;
      end
    end
  end

  assign res_a_o      = res_q[0];
  assign res_b_o      = res_q[1];
  assign res_c_o      = res_q[2];
  assign frame_done_o = fdone_q;

  `SCRB_ASSERT_IMP(a_div_owner, div_done, (state_q == S_HWAIT) || (state_q == S_VWAIT), "divider result with no pass waiting")
  `SCRB_ASSERT_IMP(a_store_quiet, state_q == S_VMAC, !mem_we, "row store written during vertical read")
  `SCRB_ASSERT_NXT(a_frame_wrap, out_acc && frame_done_o, (ocol_q == '0) && (orow_q == '0) && (irow_q == '0), "counters not cleared after last beat of frame")

endmodule

FILE: test/separable_convolution_replicate_border_tb.sv
module separable_convolution_replicate_border_tb;
  import scrb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF       = 1;
  localparam int SPAN       = 2 * HALF + 1;
  localparam int MAXW       = 1024;
  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE     = 300;
  localparam int LONG_HOLD  = 400;
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;

  typedef struct {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [15:0] c;
    logic               done;
  } filtered_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready;
  logic        opcode;
  logic [7:0]  chan_a;
  logic [7:0]  chan_b;
  logic [7:0]  chan_c;
  logic        out_valid;
  logic        out_ready;
  logic signed [15:0] res_a;
  logic signed [15:0] res_b;
  logic signed [15:0] res_c;
  logic        frame_done;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [55:0] cfg_data;

  filtered_t expected_pixels[$];
  int        errors;
  int        idle_cycles;
  bit        stall_en;
  bit        long_hold;

  logic [10:0] m_width;
  logic [11:0] m_height;
  logic        m_three;
  logic [55:0] m_htaps;
  logic [55:0] m_vtaps;
  logic [11:0] m_div;
  logic signed [15:0] row_store [0:SPAN*MAXW-1][0:2];
  logic [7:0]  pix_win [0:SPAN-1][0:2];
  int unsigned in_row, in_col, out_row, out_col;

  separable_convolution_replicate_border dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .opcode_i     (opcode),
    .chan_a_i     (chan_a),
    .chan_b_i     (chan_b),
    .chan_c_i     (chan_c),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .res_a_o      (res_a),
    .res_b_o      (res_b),
    .res_c_o      (res_c),
    .frame_done_o (frame_done),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic int unsigned eff_width();
    int unsigned v;
    v = m_width;
    if (v < 1) v = 1;
    if (v > MAXW) v = MAXW;
    return v;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned v;
    v = m_height;
    if (v < 1) v = 1;
    return v;
  endfunction

  function automatic int tap(logic [55:0] r, int t);
    return int'($signed(r[8*t +: 8]));
  endfunction

  function automatic logic signed [15:0] scale(int s);
    int d;
    d = int'($signed(m_div));
    if (d != 0) s = s / d;
    return s[15:0];
  endfunction

  function automatic logic [55:0] rand56();
    return {$urandom, $urandom};
  endfunction

  task automatic clear_counters();
    in_row = 0;
    in_col = 0;
    out_row = 0;
    out_col = 0;
  endtask

  task automatic apply_cfg(logic [2:0] idx, logic [55:0] data);
    case (idx)
      REG_FRAME_WIDTH: begin
        m_width = data[10:0];
        clear_counters();
      end
      REG_FRAME_HEIGHT: begin
        m_height = data[11:0];
        clear_counters();
      end
      REG_THREE_CHAN: begin
        m_three = data[0];
        clear_counters();
      end
      REG_H_TAPS: m_htaps = data;
      REG_V_TAPS: m_vtaps = data;
      REG_NORM_DIV: m_div = data[11:0];
      default: ;
    endcase
  endtask

  task automatic row_pass(int unsigned r, int unsigned j, int unsigned w);
    int slot, col, sum;
    slot = (r % SPAN) * MAXW + j;
    for (int ch = 0; ch < 3; ch++) begin
      sum = 0;
      for (int k = 0; k < SPAN; k++) begin
        col = int'(j) + k - HALF;
        if (col < 0) col = 0;
        if (col > int'(w) - 1) col = int'(w) - 1;
        sum += int'(pix_win[col % SPAN][ch]) * tap(m_htaps, k);
      end
      row_store[slot][ch] = scale(sum);
    end
  endtask

  function automatic bit result_ready(int unsigned w, int unsigned h);
    int unsigned nr, nc;
    if (out_row >= h) return 0;
    nr = out_row + HALF;
    if (nr > h - 1) nr = h - 1;
    nc = out_col + HALF;
    if (nc > w - 1) nc = w - 1;
    return (in_row * w + in_col) > (nr * w + nc);
  endfunction

  task automatic column_pass(int unsigned w, int unsigned h);
    filtered_t e;
    logic signed [15:0] v[3];
    int sum, row;
    for (int ch = 0; ch < 3; ch++) begin
      sum = 0;
      for (int t = 0; t < SPAN; t++) begin
        row = int'(out_row) + t - HALF;
        if (row < 0) row = 0;
        if (row > int'(h) - 1) row = int'(h) - 1;
        sum += int'(row_store[(row % SPAN) * MAXW + out_col][ch]) * tap(m_vtaps, t);
      end
      v[ch] = scale(sum);
      if (ch > 0 && !m_three) v[ch] = '0;
    end
    e.a = v[0];
    e.b = v[1];
    e.c = v[2];
    e.done = (out_row == h - 1) && (out_col == w - 1);
    expected_pixels.push_back(e);
    if (e.done) begin
      clear_counters();
    end else if (++out_col >= w) begin
      out_col = 0;
      out_row++;
    end
  endtask

  task automatic convolve_item(logic op, logic [7:0] a, logic [7:0] b, logic [7:0] c);
    int unsigned w, h, j;
    int n;
    w = eff_width();
    h = eff_height();
    n = 0;
    if (op == OP_PIXEL) begin
      if (in_row >= h) return;
      pix_win[in_col % SPAN][0] = a;
      pix_win[in_col % SPAN][1] = m_three ? b : 8'd0;
      pix_win[in_col % SPAN][2] = m_three ? c : 8'd0;
      if (in_col >= HALF) row_pass(in_row, in_col - HALF, w);
      if (in_col == w - 1) begin
        j = (in_col >= HALF) ? in_col - HALF + 1 : 0;
        for (; j < w; j++) row_pass(in_row, j, w);
      end
      if (++in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      while (n < HALF + 1 && result_ready(w, h)) begin
        column_pass(w, h);
        n++;
      end
    end else if (result_ready(w, h)) begin
      column_pass(w, h);
    end
  endtask

  task automatic send_beat(logic op, logic [7:0] a, logic [7:0] b, logic [7:0] c);
    if (stall_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    chan_a   <= a;
    chan_b   <= b;
    chan_c   <= c;
    do @(posedge clk_i); while (!in_ready);
    convolve_item(op, a, b, c);
  endtask

  task automatic send_pixel();
    send_beat(OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [55:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    apply_cfg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_frame(int w, int h, bit three);
    cfg_write(REG_FRAME_WIDTH, 56'(w));
    cfg_write(REG_FRAME_HEIGHT, 56'(h));
    cfg_write(REG_THREE_CHAN, 56'(three));
  endtask

  // drain until the frame's last result has been released
  task automatic flush_frame();
    while (in_row >= eff_height()) send_beat(OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic test_directed_frame();
    set_frame(3, 3, 1);
    cfg_write(REG_H_TAPS, 56'hFF_FFFF_FF01_807F);
    cfg_write(REG_V_TAPS, 56'h00_0000_0080_7F01);
    cfg_write(REG_NORM_DIV, 56'(0));
    for (int i = 0; i < 9; i++) begin
      if (i % 2 == 0) send_beat(OP_PIXEL, 8'hFF, 8'h00, 8'hFF);
      else send_beat(OP_PIXEL, 8'h00, 8'hFF, 8'h00);
    end
    send_beat(OP_PIXEL, 8'h55, 8'hAA, 8'h55);
    flush_frame();
    send_beat(OP_DRAIN, 8'h00, 8'h00, 8'h00);
    settle();
  endtask

  task automatic test_divisor_and_spare_regs();
    cfg_write(REG_SPARE_6, rand56());
    cfg_write(REG_SPARE_7, rand56());
    set_frame(2, 2, 0);
    cfg_write(REG_H_TAPS, 56'h00_0000_007F_7F7F);
    cfg_write(REG_V_TAPS, 56'h00_0000_0080_8080);
    cfg_write(REG_NORM_DIV, 56'(12'(-1024)));
    repeat (4) send_beat(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    flush_frame();
    settle();
    cfg_write(REG_NORM_DIV, 56'(1024));
    repeat (4) send_pixel();
    flush_frame();
    settle();
    cfg_write(REG_NORM_DIV, 56'(12'(-1)));
    repeat (4) send_pixel();
    flush_frame();
    settle();
  endtask

  task automatic test_geometry_extremes();
    set_frame(0, 0, 1);
    send_pixel();
    flush_frame();
    settle();
    // abandon a huge frame part-way
    set_frame(2047, 4095, 0);
    repeat (4) send_pixel();
    settle();
    set_frame(1, 3, 1);
    repeat (3) send_pixel();
    flush_frame();
    settle();
  endtask

  task automatic test_random_frames();
    int sent, w, h;
    sent = 0;
    long_hold = 1'b1;
    while (sent < 210) begin
      if (sent > 170) stall_en = 1'b0;
      w = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 6);
      h = $urandom_range(1, 5);
      set_frame(w, h, $urandom_range(0, 1));
      cfg_write(REG_H_TAPS, rand56());
      cfg_write(REG_V_TAPS, rand56());
      case ($urandom_range(0, 4))
        0: cfg_write(REG_NORM_DIV, 56'(0));
        1: cfg_write(REG_NORM_DIV, 56'(12'($urandom_range(0, 1) ? -1024 : 1024)));
        default: cfg_write(REG_NORM_DIV, 56'(12'(int'($urandom_range(0, 2048)) - 1024)));
      endcase
      for (int i = 0; i < w * h; i++) begin
        if ($urandom_range(0, 9) == 0) send_beat(OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
        if ($urandom_range(0, 29) == 0 && i > 0) break;
        send_pixel();
        sent++;
      end
      if (in_row >= eff_height() && $urandom_range(0, 3) == 0) send_pixel();
      flush_frame();
      settle();
    end
  endtask

  initial begin
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    opcode    = OP_PIXEL;
    chan_a    = '0;
    chan_b    = '0;
    chan_c    = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    errors    = 0;
    stall_en  = 1'b1;
    long_hold = 1'b0;
    m_width   = 11'd640;
    m_height  = 12'd480;
    m_three   = 1'b0;
    m_htaps   = '0;
    m_vtaps   = '0;
    m_div     = '0;
    for (int i = 0; i < SPAN; i++) for (int ch = 0; ch < 3; ch++) pix_win[i][ch] = '0;
    clear_counters();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_frame();
    test_divisor_and_spare_regs();
    test_geometry_extremes();
    test_random_frames();
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    out_ready = 1'b1;
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_hold = 1'b0;
        out_ready <= 1'b1;
      end else if (stall_en && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    filtered_t e;
    if (rst_ni && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected result beat a=%0d b=%0d c=%0d", res_a, res_b, res_c);
        errors++;
      end else begin
        e = expected_pixels.pop_front();
        if (res_a !== e.a) begin
          $error("res_a expected %0d actual %0d", e.a, res_a);
          errors++;
        end
        if (res_b !== e.b) begin
          $error("res_b expected %0d actual %0d", e.b, res_b);
          errors++;
        end
        if (res_c !== e.c) begin
          $error("res_c expected %0d actual %0d", e.c, res_c);
          errors++;
        end
        if (frame_done !== e.done) begin
          $error("frame_done expected %0b actual %0b", e.done, frame_done);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/scrb_pkg.sv
rtl/scrb_div.sv
rtl/separable_convolution_replicate_border.sv
test/separable_convolution_replicate_border_tb.sv
